[hw/rtl/kce_pkg.sv]
// Package: shared codes, register defaults and arithmetic helpers of the k-means engine.
`timescale 1ns / 1ps
`default_nettype none
package kce_pkg;

  typedef enum logic [1:0] {
    FUNC_LOAD_CENT  = 2'd0,
    FUNC_LOAD_POINT = 2'd1,
    FUNC_RUN        = 2'd2
  } func_e;

  typedef enum logic [2:0] {
    CFG_NUM_CLUSTERS = 3'd0,
    CFG_NUM_POINTS   = 3'd1,
    CFG_NUM_DIMS     = 3'd2,
    CFG_MAX_ITER     = 3'd3,
    CFG_MOVE_LIMIT   = 3'd4
  } cfg_idx_e;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [3:0]  RST_NUM_CLUSTERS = 4'd2;
  localparam logic [10:0] RST_NUM_POINTS   = 11'd1024;
  localparam logic [3:0]  RST_NUM_DIMS     = 4'd2;
  localparam logic [6:0]  RST_MAX_ITER     = 7'd100;
  localparam logic [31:0] RST_MOVE_LIMIT   = 32'd65536;

  // Saturating 64-bit add
  function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[64] ? '1 : s[63:0];
  endfunction

  // Squared difference of two coordinates, saturating once |a-b| leaves 32 bits
  function automatic logic [63:0] sat_sq(input logic signed [32:0] a,
                                         input logic signed [32:0] b);
    logic signed [33:0] d;
    logic [33:0]        ad;
    logic [31:0]        am;
    d  = {a[32], a} - {b[32], b};
    ad = d[33] ? 34'(-d) : 34'(d);
    am = ad[31:0];
    if (ad[33:32] != 2'b00) begin
      return '1;
    end
    return 64'(am) * 64'(am);
  endfunction

endpackage
`default_nettype wire

[hw/rtl/kce_if.sv]
// Interfaces: item channels into and out of the k-means engine.
`timescale 1ns / 1ps
`default_nettype none
interface kce_in_if #(parameter int unsigned COORD_BITS = 16);
  logic                  valid;
  logic                  ready;
  logic [1:0]            func;
  logic [9:0]            index;
  logic [2:0]            dim;
  logic [COORD_BITS-1:0] value;

  modport source (output valid, func, index, dim, value, input ready);
  modport sink   (input valid, func, index, dim, value, output ready);
endinterface

interface kce_out_if #(parameter int unsigned COORD_BITS = 16);
  logic                  valid;
  logic                  ready;
  logic [2:0]            cluster;
  logic [2:0]            dim_res;
  logic [COORD_BITS-1:0] coordinate;
  logic [6:0]            iterations;
  logic                  last;

  modport source (output valid, cluster, dim_res, coordinate, iterations, last,
                  input ready);
  modport sink   (input valid, cluster, dim_res, coordinate, iterations, last,
                  output ready);
endinterface
`default_nettype wire

[hw/rtl/kce_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module kce_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                             clk_i,
  input  wire logic                             we_i,
  input  wire logic [$clog2(DEPTH)-1:0]         waddr_i,
  input  wire logic [WIDTH-1:0]                 wdata_i,
  input  wire logic                             re_i,
  input  wire logic [$clog2(DEPTH)-1:0]         raddr_i,
  output logic      [WIDTH-1:0]                 rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

[hw/rtl/kce_div.sv]
// Restoring divider: one quotient bit per cycle, unsigned operands.
`timescale 1ns / 1ps
`default_nettype none
module kce_div #(
  parameter int unsigned NW  = 26,
  parameter int unsigned DVW = 11
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           start_i,
  input  wire logic [NW-1:0]  dividend_i,
  input  wire logic [DVW-1:0] divisor_i,
  output logic      [NW-1:0]  quotient_o,
  output logic                done_o
);

  localparam int unsigned NCW = $clog2(NW + 1);

  logic           busy_q, done_q;
  logic [NCW-1:0] cnt_q;
  logic [NW-1:0]  quo_q;
  logic [DVW-1:0] rem_q, dvs_q;
  logic [DVW:0]   trial, diff;
  logic           ge;

  assign trial = {rem_q, quo_q[NW-1]};
  assign ge    = trial >= {1'b0, dvs_q};
  assign diff  = trial - {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= NCW'(NW);
    end else if (busy_q) begin
      cnt_q <= cnt_q - NCW'(1);
      if (cnt_q == NCW'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= ge ? diff[DVW-1:0] : trial[DVW-1:0];
      quo_q <= {quo_q[NW-2:0], ge};
    end
  end

  assign quotient_o = quo_q;
  assign done_o     = done_q;

endmodule
`default_nettype wire

[hw/rtl/kmeans_clustering_engine.sv]
// Top level: Lloyd k-means engine with point, centroid and sum memories.
// Use:
//   Input channel in_i (valid/ready) carries load and run items. A load item
//   writes one centroid coordinate (into the current bank) or one point
//   coordinate; while the engine is idle, loads stream at one item a cycle.
//   A run item walks all points per Lloyd iteration and then emits every
//   centroid coordinate of the k clusters on out_o, last set on the final one.
//   Configuration registers are written through cfg_we_i/cfg_idx_i/cfg_wdata_i
//   by the user only while the engine is idle; the block does not enforce this.
// Steps of a run, per iteration (n points, k clusters, d dims, K*D sum entries):
//   clear of all MAX_CLUSTERS*MAX_DIMS sum entries; per point, the distance to each
//   centroid and an add into the nearest one's sums; per coordinate, a divide of
//   SW bits (SW is the sum width). Distance terms use both read ports one element a step.
//   Emission then registers each result and holds it until the receiver takes it.
// in_i.ready is high only while idle. A stalled receiver holds the result in
// the output register; the engine waits. Reset returns registers to their
// defaults, clears the iteration count and bank select; memories keep
// undefined content until loaded.
`timescale 1ns / 1ps
`default_nettype none
module kmeans_clustering_engine
  import kce_pkg::*;
#(
  parameter int unsigned MAX_CLUSTERS = 8,
  parameter int unsigned MAX_POINTS   = 1024,
  parameter int unsigned MAX_DIMS     = 8,
  parameter int unsigned COORD_BITS   = 16
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  kce_in_if.sink                     in_i,
  kce_out_if.source                  out_o,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  localparam int unsigned CB  = COORD_BITS;
  localparam int unsigned KW  = $clog2(MAX_CLUSTERS);
  localparam int unsigned DW  = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
  localparam int unsigned PW  = $clog2(MAX_POINTS);
  localparam int unsigned CD  = MAX_CLUSTERS * MAX_DIMS;
  localparam int unsigned CDW = $clog2(CD);
  localparam int unsigned CA  = $clog2(2 * CD);
  localparam int unsigned PD  = MAX_POINTS * MAX_DIMS;
  localparam int unsigned PA  = $clog2(PD);
  localparam int unsigned SW  = CB + $clog2(MAX_POINTS);
  localparam int unsigned CW  = $clog2(MAX_POINTS + 1);

  typedef enum logic [15:0] {
    S_IDLE  = 16'h0001,
    S_CLR   = 16'h0002,
    S_AREQ  = 16'h0004,
    S_ASQ   = 16'h0008,
    S_AACC  = 16'h0010,
    S_SREQ  = 16'h0020,
    S_SWR   = 16'h0040,
    S_UREQ  = 16'h0080,
    S_UDIV  = 16'h0100,
    S_UWAIT = 16'h0200,
    S_UWR   = 16'h0400,
    S_UACC  = 16'h0800,
    S_ITER  = 16'h1000,
    S_OREQ  = 16'h2000,
    S_OSHOW = 16'h4000,
    S_OWAIT = 16'h8000
  } state_e;

  // Configuration registers
  logic [3:0]  ncl_q;
  logic [10:0] npt_q;
  logic [3:0]  ndm_q;
  logic [6:0]  mit_q;
  logic [31:0] lim_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ncl_q <= RST_NUM_CLUSTERS;
      npt_q <= RST_NUM_POINTS;
      ndm_q <= RST_NUM_DIMS;
      mit_q <= RST_MAX_ITER;
      lim_q <= RST_MOVE_LIMIT;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_NUM_CLUSTERS: ncl_q <= cfg_wdata_i[3:0];
        CFG_NUM_POINTS:   npt_q <= cfg_wdata_i[10:0];
        CFG_NUM_DIMS:     ndm_q <= cfg_wdata_i[3:0];
        CFG_MAX_ITER:     mit_q <= cfg_wdata_i[6:0];
        CFG_MOVE_LIMIT:   lim_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Saturated loop bounds
  logic [KW-1:0] k_m1;
  logic [PW-1:0] n_m1;
  logic [DW-1:0] nd_m1;
  logic [6:0]    cap;

  always_comb begin
    if (ncl_q == 4'd0) begin
      k_m1 = '0;
    end else if (32'(ncl_q) > 32'(MAX_CLUSTERS)) begin
      k_m1 = KW'(MAX_CLUSTERS - 1);
    end else begin
      k_m1 = KW'(ncl_q - 4'd1);
    end
    if (npt_q == 11'd0) begin
      n_m1 = '0;
    end else if (32'(npt_q) > 32'(MAX_POINTS)) begin
      n_m1 = PW'(MAX_POINTS - 1);
    end else begin
      n_m1 = PW'(npt_q - 11'd1);
    end
    if (ndm_q == 4'd0) begin
      nd_m1 = '0;
    end else if (32'(ndm_q) > 32'(MAX_DIMS)) begin
      nd_m1 = DW'(MAX_DIMS - 1);
    end else begin
      nd_m1 = DW'(ndm_q - 4'd1);
    end
    cap = (mit_q == 7'd0) ? 7'd1 : mit_q;
  end

  function automatic logic [CA-1:0] cent_addr(input logic b, input logic [KW-1:0] c,
                                              input logic [DW-1:0] j);
    return CA'(CA'(b) * CA'(CD) + CA'(c) * CA'(MAX_DIMS) + CA'(j));
  endfunction

  function automatic logic [CDW-1:0] sum_addr(input logic [KW-1:0] c,
                                              input logic [DW-1:0] j);
    return CDW'(CDW'(c) * CDW'(MAX_DIMS) + CDW'(j));
  endfunction

  function automatic logic signed [32:0] sx(input logic [CB-1:0] x);
    return {{(33 - CB){x[CB-1]}}, x};
  endfunction

  // Memory ports
  logic          pt_we, pt_re;
  logic [PA-1:0] pt_waddr, pt_raddr;
  logic [CB-1:0] pt_rd;
  logic          ct_we, ct_re;
  logic [CA-1:0] ct_waddr, ct_raddr;
  logic [CB-1:0] ct_wdata, ct_rd;
  logic           sm_we, sm_re;
  logic [CDW-1:0] sm_waddr, sm_raddr;
  logic [SW-1:0]  sm_wdata, sm_rd;

  kce_ram #(.WIDTH(CB), .DEPTH(PD)) u_point_ram (
    .clk_i, .we_i(pt_we), .waddr_i(pt_waddr), .wdata_i(in_i.value),
    .re_i(pt_re), .raddr_i(pt_raddr), .rdata_o(pt_rd)
  );

  kce_ram #(.WIDTH(CB), .DEPTH(2 * CD)) u_cent_ram (
    .clk_i, .we_i(ct_we), .waddr_i(ct_waddr), .wdata_i(ct_wdata),
    .re_i(ct_re), .raddr_i(ct_raddr), .rdata_o(ct_rd)
  );

  kce_ram #(.WIDTH(SW), .DEPTH(CD)) u_sum_ram (
    .clk_i, .we_i(sm_we), .waddr_i(sm_waddr), .wdata_i(sm_wdata),
    .re_i(sm_re), .raddr_i(sm_raddr), .rdata_o(sm_rd)
  );

  // Control and datapath registers
  state_e         state_q, state_d;
  logic [KW-1:0]  c_q, c_d, best_q, best_d;
  logic [DW-1:0]  j_q, j_d;
  logic [PW-1:0]  i_q, i_d;
  logic [CDW-1:0] clr_q, clr_d;
  logic [63:0]    dist_q, dist_d, dmin_q, dmin_d, sq_q, sq_d, move_q, move_d;
  logic           moved_q, moved_d, bank_q, bank_d;
  logic [6:0]     iter_q, iter_d;
  logic [CW-1:0]  cnt_q [MAX_CLUSTERS];
  logic [CW-1:0]  cnt_d [MAX_CLUSTERS];
  logic           out_valid_q, out_valid_d, out_last_q, out_last_d;
  logic [2:0]     out_cl_q, out_cl_d, out_dm_q, out_dm_d;
  logic [CB-1:0]  out_co_q, out_co_d;

  // Divider
  logic          div_start, div_done;
  logic [SW-1:0] div_q, sum_abs;
  logic [KW-1:0] cnt_idx;
  logic [CW-1:0] cnt_rd;
  logic signed [SW-1:0] sum_s, quo_s;
  logic [CB-1:0] new_co;
  logic [63:0]   dsum, msum;
  logic          in_acc, out_acc;

  assign cnt_idx = (state_q == S_UDIV || state_q == S_UWAIT || state_q == S_UWR)
                   ? c_q : best_q;
  assign cnt_rd  = cnt_q[cnt_idx];
  assign sum_s   = sm_rd;
  assign sum_abs = sum_s[SW-1] ? SW'(-sum_s) : SW'(sum_s);
  assign quo_s   = sum_s[SW-1] ? -$signed(div_q) : $signed(div_q);
  assign new_co  = (cnt_rd == '0) ? ct_rd : CB'(quo_s);
  assign dsum    = sat_add(dist_q, sq_q);
  assign msum    = sat_add(move_q, sq_q);

  kce_div #(.NW(SW), .DVW(CW)) u_div (
    .clk_i, .rst_ni, .start_i(div_start), .dividend_i(sum_abs),
    .divisor_i(cnt_rd), .quotient_o(div_q), .done_o(div_done)
  );

  assign in_i.ready = (state_q == S_IDLE);
  assign in_acc     = in_i.valid && in_i.ready;
  assign out_acc    = out_valid_q && out_o.ready;

  always_comb begin
    state_d     = state_q;
    c_d         = c_q;
    j_d         = j_q;
    i_d         = i_q;
    best_d      = best_q;
    clr_d       = clr_q;
    dist_d      = dist_q;
    dmin_d      = dmin_q;
    sq_d        = sq_q;
    move_d      = move_q;
    moved_d     = moved_q;
    bank_d      = bank_q;
    iter_d      = iter_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q;
    out_last_d  = out_last_q;
    out_cl_d    = out_cl_q;
    out_dm_d    = out_dm_q;
    out_co_d    = out_co_q;
    pt_we       = 1'b0;
    pt_re       = 1'b0;
    pt_waddr    = PA'(32'(in_i.index) * MAX_DIMS + 32'(in_i.dim));
    pt_raddr    = PA'(PA'(i_q) * PA'(MAX_DIMS) + PA'(j_q));
    ct_we       = 1'b0;
    ct_re       = 1'b0;
    ct_waddr    = cent_addr(bank_q, KW'(in_i.index), DW'(in_i.dim));
    ct_wdata    = in_i.value;
    ct_raddr    = cent_addr(bank_q, c_q, j_q);
    sm_we       = 1'b0;
    sm_re       = 1'b0;
    sm_waddr    = clr_q;
    sm_wdata    = '0;
    sm_raddr    = sum_addr(best_q, j_q);
    div_start   = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          case (in_i.func)
            FUNC_LOAD_CENT: begin
              ct_we = (32'(in_i.index) < MAX_CLUSTERS) && (32'(in_i.dim) < MAX_DIMS);
            end
            FUNC_LOAD_POINT: begin
              pt_we = (32'(in_i.index) < MAX_POINTS) && (32'(in_i.dim) < MAX_DIMS);
            end
            FUNC_RUN: begin
              iter_d  = '0;
              moved_d = 1'b0;
              clr_d   = '0;
              state_d = S_CLR;
            end
            default: ;
          endcase
        end
      end
      S_CLR: begin
        sm_we = 1'b1;
        for (int k = 0; k < MAX_CLUSTERS; k++) begin
          cnt_d[k] = '0;
        end
        if (clr_q == CDW'(CD - 1)) begin
          i_d     = '0;
          c_d     = '0;
          j_d     = '0;
          dist_d  = '0;
          state_d = S_AREQ;
        end else begin
          clr_d = clr_q + CDW'(1);
        end
      end
      S_AREQ: begin
        pt_re   = 1'b1;
        ct_re   = 1'b1;
        state_d = S_ASQ;
      end
      S_ASQ: begin
        sq_d    = sat_sq(sx(pt_rd), sx(ct_rd));
        state_d = S_AACC;
      end
      S_AACC: begin
        if (j_q == nd_m1) begin
          // Strict compare keeps the lowest cluster on a tie
          if (c_q == '0 || dsum < dmin_q) begin
            dmin_d = dsum;
            best_d = c_q;
          end
          dist_d = '0;
          j_d    = '0;
          if (c_q == k_m1) begin
            state_d = S_SREQ;
          end else begin
            c_d     = c_q + KW'(1);
            state_d = S_AREQ;
          end
        end else begin
          dist_d  = dsum;
          j_d     = j_q + DW'(1);
          state_d = S_AREQ;
        end
      end
      S_SREQ: begin
        pt_re   = 1'b1;
        sm_re   = 1'b1;
        state_d = S_SWR;
      end
      S_SWR: begin
        sm_we    = 1'b1;
        sm_waddr = sum_addr(best_q, j_q);
        sm_wdata = SW'(sum_s + SW'($signed(pt_rd)));
        if (j_q == nd_m1) begin
          cnt_d[best_q] = cnt_rd + CW'(1);
          j_d           = '0;
          c_d           = '0;
          if (i_q == n_m1) begin
            move_d  = '0;
            state_d = S_UREQ;
          end else begin
            i_d     = i_q + PW'(1);
            dist_d  = '0;
            state_d = S_AREQ;
          end
        end else begin
          j_d     = j_q + DW'(1);
          state_d = S_SREQ;
        end
      end
      S_UREQ: begin
        sm_raddr = sum_addr(c_q, j_q);
        sm_re    = 1'b1;
        ct_re    = 1'b1;
        state_d  = S_UDIV;
      end
      S_UDIV: begin
        // Empty cluster skips the divider and keeps its centroid
        if (cnt_rd != '0) begin
          div_start = 1'b1;
          state_d   = S_UWAIT;
        end else begin
          state_d = S_UWR;
        end
      end
      S_UWAIT: begin
        if (div_done) begin
          state_d = S_UWR;
        end
      end
      S_UWR: begin
        ct_we    = 1'b1;
        ct_waddr = cent_addr(!bank_q, c_q, j_q);
        ct_wdata = new_co;
        sq_d     = sat_sq(sx(new_co), sx(ct_rd));
        state_d  = S_UACC;
      end
      S_UACC: begin
        if (j_q == nd_m1) begin
          if (msum > 64'(lim_q)) begin
            moved_d = 1'b1;
          end
          move_d = '0;
          j_d    = '0;
          if (c_q == k_m1) begin
            state_d = S_ITER;
          end else begin
            c_d     = c_q + KW'(1);
            state_d = S_UREQ;
          end
        end else begin
          move_d  = msum;
          j_d     = j_q + DW'(1);
          state_d = S_UREQ;
        end
      end
      S_ITER: begin
        bank_d = !bank_q;
        iter_d = iter_q + 7'd1;
        c_d    = '0;
        j_d    = '0;
        if (moved_q && (iter_q + 7'd1) < cap) begin
          moved_d = 1'b0;
          clr_d   = '0;
          state_d = S_CLR;
        end else begin
          state_d = S_OREQ;
        end
      end
      S_OREQ: begin
        ct_re   = 1'b1;
        state_d = S_OSHOW;
      end
      S_OSHOW: begin
        out_valid_d = 1'b1;
        out_cl_d    = 3'(c_q);
        out_dm_d    = 3'(j_q);
        out_co_d    = ct_rd;
        out_last_d  = (c_q == k_m1) && (j_q == nd_m1);
        state_d     = S_OWAIT;
      end
      S_OWAIT: begin
        if (out_acc) begin
          out_valid_d = 1'b0;
          if (out_last_q) begin
            state_d = S_IDLE;
          end else if (j_q == nd_m1) begin
            j_d     = '0;
            c_d     = c_q + KW'(1);
            state_d = S_OREQ;
          end else begin
            j_d     = j_q + DW'(1);
            state_d = S_OREQ;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      c_q         <= '0;
      j_q         <= '0;
      i_q         <= '0;
      best_q      <= '0;
      clr_q       <= '0;
      moved_q     <= 1'b0;
      bank_q      <= 1'b0;
      iter_q      <= '0;
      out_valid_q <= 1'b0;
      for (int k = 0; k < MAX_CLUSTERS; k++) begin
        cnt_q[k] <= '0;
      end
    end else begin
      state_q     <= state_d;
      c_q         <= c_d;
      j_q         <= j_d;
      i_q         <= i_d;
      best_q      <= best_d;
      clr_q       <= clr_d;
      moved_q     <= moved_d;
      bank_q      <= bank_d;
      iter_q      <= iter_d;
      out_valid_q <= out_valid_d;
      cnt_q       <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dist_q     <= dist_d;
    dmin_q     <= dmin_d;
    sq_q       <= sq_d;
    move_q     <= move_d;
    out_last_q <= out_last_d;
    out_cl_q   <= out_cl_d;
    out_dm_q   <= out_dm_d;
    out_co_q   <= out_co_d;
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.cluster    = out_cl_q;
  assign out_o.dim_res    = out_dm_q;
  assign out_o.coordinate = out_co_q;
  assign out_o.iterations = iter_q;
  assign out_o.last       = out_last_q;

`ifndef NO_ASSERTIONS
  a_out_only_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> state_q == S_OWAIT)
    else $error("result shown outside the emit wait");

  a_no_in_while_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.ready |-> !out_valid_q)
    else $error("item taken while a result is pending");

  a_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> cnt_rd != '0)
    else $error("divider started on an empty cluster");

  a_iter_le_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (iter_q != 7'd0 && iter_q <= cap))
    else $error("iteration count outside the cap");
`endif

endmodule
`default_nettype wire

[tb/sv/kmeans_clustering_engine_tb.sv]
// Testbench: loads centroid and point sets, runs Lloyd clustering and checks every centroid item.
`timescale 1ns / 1ps
module kmeans_clustering_engine_tb;
  import kce_pkg::*;

  localparam int unsigned NCL = 8;
  localparam int unsigned NPT = 1024;
  localparam int unsigned NDM = 8;

  typedef struct packed {
    logic [2:0]  cluster;
    logic [2:0]  dim_res;
    logic [15:0] coordinate;
    logic [6:0]  iterations;
    logic        last;
  } centroid_res_t;

  class centroid_board;
    longint        cent[2][NCL][NDM];
    longint        pts[NPT][NDM];
    bit            bank;
    logic [3:0]    k_reg;
    logic [10:0]   n_reg;
    logic [3:0]    d_reg;
    logic [6:0]    iter_reg;
    logic [31:0]   limit_reg;
    centroid_res_t exp_q[$];
    int            fails;
    int            checked;
    int            runs;
    int            items;

    function new();
      bank      = 0;
      k_reg     = RST_NUM_CLUSTERS;
      n_reg     = RST_NUM_POINTS;
      d_reg     = RST_NUM_DIMS;
      iter_reg  = RST_MAX_ITER;
      limit_reg = RST_MOVE_LIMIT;
    endfunction

    function int eff_k();
      return (k_reg == 0) ? 1 : ((k_reg > NCL) ? NCL : int'(k_reg));
    endfunction
    function int eff_n();
      return (n_reg == 0) ? 1 : ((n_reg > NPT) ? NPT : int'(n_reg));
    endfunction
    function int eff_d();
      return (d_reg == 0) ? 1 : ((d_reg > NDM) ? NDM : int'(d_reg));
    endfunction

    function void set_reg(cfg_idx_e idx, logic [31:0] val);
      case (idx)
        CFG_NUM_CLUSTERS: k_reg = val[3:0];
        CFG_NUM_POINTS:   n_reg = val[10:0];
        CFG_NUM_DIMS:     d_reg = val[3:0];
        CFG_MAX_ITER:     iter_reg = val[6:0];
        CFG_MOVE_LIMIT:   limit_reg = val;
        default: ;
      endcase
    endfunction

    function void report(string msg);
      $display("MISMATCH @%0t: %s", $realtime, msg);
      fails++;
    endfunction

    // One Lloyd step from the current bank into the other; returns 1 on a large move
    function bit lloyd_step(int k, int n, int nd);
      longint              sums[NCL][NDM];
      int                  cnt[NCL];
      longint unsigned     dd;
      longint unsigned     dmin;
      longint              diff;
      int                  best;
      bit                  nb;
      bit                  moved;
      nb    = ~bank;
      moved = 0;
      for (int c = 0; c < NCL; c++) begin
        cnt[c] = 0;
        for (int j = 0; j < NDM; j++) sums[c][j] = 0;
      end
      for (int i = 0; i < n; i++) begin
        best = 0;
        dmin = 0;
        for (int c = 0; c < k; c++) begin
          dd = 0;
          for (int j = 0; j < nd; j++) begin
            diff = cent[bank][c][j] - pts[i][j];
            dd += longint'(diff * diff);
          end
          // strict less keeps ties on the lowest cluster
          if (c == 0 || dd < dmin) begin
            dmin = dd;
            best = c;
          end
        end
        cnt[best]++;
        for (int j = 0; j < nd; j++) sums[best][j] += pts[i][j];
      end
      for (int c = 0; c < k; c++) begin
        dd = 0;
        for (int j = 0; j < nd; j++) begin
          if (cnt[c] == 0) cent[nb][c][j] = cent[bank][c][j];
          else cent[nb][c][j] = sums[c][j] / longint'(cnt[c]);
          diff = cent[nb][c][j] - cent[bank][c][j];
          dd += longint'(diff * diff);
        end
        if (dd > longint'(limit_reg)) moved = 1;
      end
      bank = nb;
      return moved;
    endfunction

    function void note_item(logic [1:0] fn, logic [9:0] idx, logic [2:0] dm,
                            logic [15:0] val);
      int            k;
      int            n;
      int            nd;
      int            cap;
      int            iter;
      bit            moved;
      centroid_res_t r;
      items++;
      if (fn == FUNC_LOAD_CENT) begin
        if (idx < NCL) cent[bank][idx][dm] = longint'(signed'(val));
      end else if (fn == FUNC_LOAD_POINT) begin
        pts[idx][dm] = longint'(signed'(val));
      end else if (fn == FUNC_RUN) begin
        k   = eff_k();
        n   = eff_n();
        nd  = eff_d();
        cap = (iter_reg == 0) ? 1 : int'(iter_reg);
        iter = 0;
        runs++;
        do begin
          iter++;
          moved = lloyd_step(k, n, nd);
        end while (moved && iter < cap);
        for (int c = 0; c < k; c++) begin
          for (int j = 0; j < nd; j++) begin
            r.cluster    = c[2:0];
            r.dim_res    = j[2:0];
            r.coordinate = cent[bank][c][j][15:0];
            r.iterations = iter[6:0];
            r.last       = (c == k - 1) && (j == nd - 1);
            exp_q.push_back(r);
          end
        end
      end
    endfunction

    function void check_result(centroid_res_t got);
      centroid_res_t w;
      if (exp_q.size() == 0) begin
        report($sformatf("unexpected item cl=%0d dim=%0d", got.cluster, got.dim_res));
        return;
      end
      w = exp_q.pop_front();
      checked++;
      if (got.cluster !== w.cluster)
        report($sformatf("cluster %0d, want %0d", got.cluster, w.cluster));
      if (got.dim_res !== w.dim_res)
        report($sformatf("dim_res %0d, want %0d", got.dim_res, w.dim_res));
      if (got.coordinate !== w.coordinate)
        report($sformatf("coordinate %h, want %h (cl %0d dim %0d)", got.coordinate,
                         w.coordinate, w.cluster, w.dim_res));
      if (got.iterations !== w.iterations)
        report($sformatf("iterations %0d, want %0d", got.iterations, w.iterations));
      if (got.last !== w.last)
        report($sformatf("last %b, want %b", got.last, w.last));
    endfunction
  endclass

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  bit                    tx_idle;
  bit                    rx_idle;
  bit                    hold_req;
  logic [15:0]           centre[NCL][NDM];

  kce_in_if  #(.COORD_BITS(16)) in_if ();
  kce_out_if #(.COORD_BITS(16)) out_if ();

  centroid_board sb = new();

  kmeans_clustering_engine u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_if),
    .out_o      (out_if),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata)
  );

  always #6 clk_i = ~clk_i;

  function automatic int draw_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  always @(posedge clk_i) begin
    if (in_if.valid && in_if.ready)
      sb.note_item(in_if.func, in_if.index, in_if.dim, in_if.value);
    if (out_if.valid && out_if.ready)
      sb.check_result({out_if.cluster, out_if.dim_res, out_if.coordinate,
                       out_if.iterations, out_if.last});
  end

  // Receiver: random stalls, plus one long hold-off on request
  initial begin
    int stall_left;
    stall_left = 0;
    forever begin
      @(negedge clk_i);
      if (hold_req && out_if.valid) begin
        out_if.ready <= 1'b0;
        repeat (399) @(negedge clk_i);
        hold_req = 0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_if.ready <= 1'b0;
      end else begin
        stall_left = rx_idle ? draw_gap() : 0;
        out_if.ready <= (stall_left == 0);
      end
    end
  end

  initial begin
    #(20_000_000);
    $display("CHECKS FAILED");
    $finish;
  end

  task automatic send(func_e fn, int idx, int dm, logic [15:0] val);
    int gap;
    @(negedge clk_i);
    in_if.valid <= 1'b1;
    in_if.func  <= fn;
    in_if.index <= idx[9:0];
    in_if.dim   <= dm[2:0];
    in_if.value <= val;
    do @(posedge clk_i); while (!in_if.ready);
    gap = tx_idle ? draw_gap() : 0;
    if (gap > 0) begin
      @(negedge clk_i);
      in_if.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
  endtask

  task automatic send_raw(logic [1:0] fn, logic [9:0] idx, logic [15:0] val);
    @(negedge clk_i);
    in_if.valid <= 1'b1;
    in_if.func  <= fn;
    in_if.index <= idx;
    in_if.dim   <= 3'($urandom);
    in_if.value <= val;
    do @(posedge clk_i); while (!in_if.ready);
  endtask

  task automatic wait_idle();
    @(negedge clk_i);
    in_if.valid <= 1'b0;
    while (sb.exp_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic cfg_write(cfg_idx_e idx, logic [31:0] val);
    @(negedge clk_i);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    sb.set_reg(idx, val);
    @(negedge clk_i);
    cfg_we    <= 1'b0;
  endtask

  task automatic configure(logic [31:0] k, logic [31:0] n, logic [31:0] d,
                           logic [31:0] it, logic [31:0] lim);
    cfg_write(CFG_NUM_CLUSTERS, k);
    cfg_write(CFG_NUM_POINTS, n);
    cfg_write(CFG_NUM_DIMS, d);
    cfg_write(CFG_MAX_ITER, it);
    cfg_write(CFG_MOVE_LIMIT, lim);
  endtask

  function automatic logic [15:0] near(logic [15:0] c, int spread);
    int v;
    v = int'(signed'(c)) + $urandom_range(0, 2 * spread) - spread;
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[15:0];
  endfunction

  // Load every centroid and point coordinate the next run will read
  task automatic load_set(bit wide);
    int k;
    int n;
    int nd;
    int c;
    k  = sb.eff_k();
    n  = sb.eff_n();
    nd = sb.eff_d();
    for (int i = 0; i < k; i++)
      for (int j = 0; j < nd; j++) centre[i][j] = 16'($urandom);
    for (int i = 0; i < k; i++)
      for (int j = 0; j < nd; j++)
        send(FUNC_LOAD_CENT, i, j, near(centre[$urandom_range(0, k - 1)][j], 3000));
    for (int i = 0; i < n; i++) begin
      c = $urandom_range(0, k - 1);
      for (int j = 0; j < nd; j++)
        send(FUNC_LOAD_POINT, i, j, wide ? 16'($urandom) : near(centre[c][j], 1500));
    end
  endtask

  initial begin
    int k;
    int n;
    int nd;
    clk_i        = 1'b0;
    rst_ni       = 1'b0;
    cfg_we       = 1'b0;
    cfg_idx      = '0;
    cfg_wdata    = '0;
    in_if.valid  = 1'b0;
    in_if.func   = '0;
    in_if.index  = '0;
    in_if.dim    = '0;
    in_if.value  = '0;
    out_if.ready = 1'b0;
    tx_idle      = 0;
    rx_idle      = 0;
    hold_req     = 0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    repeat (3) @(posedge clk_i);

    // Saturated registers: 8 clusters, one dim, one point, one step; ties and empty clusters
    configure(32'hF, 32'h0, 32'h0, 32'h0, 32'h0);
    send(FUNC_LOAD_CENT, 0, 0, 16'h8000);
    send(FUNC_LOAD_CENT, 1, 0, 16'h7FFF);
    send(FUNC_LOAD_CENT, 2, 0, 16'h0100);
    send(FUNC_LOAD_CENT, 3, 0, 16'h0100);
    for (int i = 4; i < NCL; i++) send(FUNC_LOAD_CENT, i, 0, 16'hFF00);
    send(FUNC_LOAD_CENT, 1023, 0, 16'h1234);
    send(FUNC_LOAD_CENT, 8, 0, 16'h5555);
    send_raw(2'b11, 10'h3FF, 16'hAAAA);
    send(FUNC_LOAD_POINT, 0, 0, 16'h0100);
    send(FUNC_RUN, 0, 0, 16'h0);
    wait_idle();

    // One cluster over all eight dims, widest limit and iteration cap
    tx_idle = 1;
    configure(32'h1, 32'h2, 32'h8, 32'h7F, 32'hFFFF_FFFF);
    for (int j = 0; j < NDM; j++) send(FUNC_LOAD_CENT, 0, j, 16'($urandom));
    for (int i = 0; i < 2; i++)
      for (int j = 0; j < NDM; j++)
        send(FUNC_LOAD_POINT, i, j, (i == 0) ? 16'h7FFF : 16'h8000);
    send(FUNC_RUN, 0, 0, 16'h0);
    wait_idle();

    // All eight clusters over a few wide points, few steps
    rx_idle = 1;
    configure(32'h8, 32'h8, 32'h1, 32'h2, 32'($urandom_range(0, 4096)));
    load_set(1);
    send(FUNC_RUN, 0, 0, 16'h0);
    wait_idle();

    for (int ph = 0; ph < 3; ph++) begin
      tx_idle = $urandom_range(0, 3) != 0;
      rx_idle = $urandom_range(0, 3) != 0;
      k  = $urandom_range(1, 5);
      nd = $urandom_range(1, 3);
      n  = $urandom_range(2, 8);
      configure(k, n, nd, $urandom_range(1, 10),
                ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 1 << 18));
      load_set($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 4) == 0) send_raw(2'b11, 10'($urandom), 16'($urandom));
      if (ph == 0) hold_req = 1;
      send(FUNC_RUN, 0, 0, 16'h0);
      // keep offering items while results drain
      if (ph == 0 || $urandom_range(0, 2) == 0) begin
        for (int j = 0; j < sb.eff_d(); j++)
          send(FUNC_LOAD_POINT, $urandom_range(0, sb.eff_n() - 1), j, 16'($urandom));
        send(FUNC_RUN, 0, 0, 16'h0);
      end
      wait_idle();
    end

    while (sb.exp_q.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    $display("Run summary: %0d clustering runs over %0d input items", sb.runs, sb.items);
    $display("  %0d centroid items compared, %0d mismatches", sb.checked, sb.fails);
    if (sb.fails == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
